FILE: rtl/fsla_pkg.sv
`timescale 1ns / 1ps

package fsla_pkg;

  // Default pool and pointer sizes
  localparam int NUM_SLOTS_DEF     = 256;
  localparam int POINTER_BYTES_DEF = 8;

  // Field widths
  localparam int SLOT_W = 8;
  localparam int OFF_W  = 20;
  localparam int OBJ_W  = 13;
  localparam int ALN_W  = 3;
  localparam int SIZE_W = 14;   // max(object, pointer) rounded up to 128 fits here
  localparam int CIDX_W = 1;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_OBJECT_BYTES = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_ALIGN_LOG2   = 1'b1;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [OBJ_W-1:0] OBJECT_BYTES_RST = 13'd8;
  localparam logic [ALN_W-1:0] ALIGN_LOG2_RST   = 3'd0;

  typedef struct packed {
    logic accept;
    logic link;
    logic mul;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

FILE: rtl/fsla_intf.sv
`timescale 1ns / 1ps

interface fsla_req_if import fsla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output req_type, output slot_index, input ready);
  modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

interface fsla_rsp_if import fsla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] slot_index_out;
  logic [OFF_W-1:0]  byte_offset;

  modport source (output valid, output ok, output slot_index_out, output byte_offset,
                  input ready);
  modport sink   (input valid, input ok, input slot_index_out, input byte_offset,
                  output ready);
endinterface

interface fsla_cfg_if import fsla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [OBJ_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fsla_ctrl.sv
`timescale 1ns / 1ps

module fsla_ctrl import fsla_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LINK = 4'b0010,
    S_MUL  = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_next = S_LINK;
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register can take the item
        if (!status.out_stall) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/fsla_datapath.sv
`timescale 1ns / 1ps

module fsla_datapath import fsla_pkg::*; #(
  parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
  parameter int POINTER_BYTES = POINTER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic              in_req_type,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic              cfg_valid,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [OBJ_W-1:0]  cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_ok,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [OFF_W-1:0]  out_byte_offset
);

  localparam int PTR_W = $clog2(NUM_SLOTS + 1);
  localparam int AW    = $clog2(NUM_SLOTS);
  localparam int EXT_W = (PTR_W > SLOT_W) ? PTR_W : SLOT_W;
  localparam int MUL_W = (PTR_W + SIZE_W > OFF_W) ? PTR_W + SIZE_W : OFF_W;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_SLOTS);

  logic [OBJ_W-1:0] object_bytes;
  logic [ALN_W-1:0] align_log2;

  logic [PTR_W-1:0] list_head;
  logic [PTR_W-1:0] fresh_count;
  logic [PTR_W-1:0] got;
  logic             ok_r;
  logic             pop;
  logic [OFF_W-1:0] offset_r;

  logic [PTR_W-1:0] link_mem [NUM_SLOTS];
  logic [PTR_W-1:0] rd_data;

  logic [EXT_W-1:0]  slot_ext;
  logic [EXT_W-1:0]  got_ext;
  logic              free_in_range;
  logic              wr_en;
  logic              rd_en;
  logic [SIZE_W-1:0] base_size;
  logic [SIZE_W-1:0] align_mask;
  logic [SIZE_W-1:0] slot_size;
  logic [MUL_W-1:0]  prod;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_bytes <= OBJECT_BYTES_RST;
      align_log2   <= ALIGN_LOG2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OBJECT_BYTES: object_bytes <= cfg_data;
        CFG_ALIGN_LOG2:   align_log2   <= cfg_data[ALN_W-1:0];
        default: ;
      endcase
    end
  end

  assign slot_ext      = EXT_W'(in_slot_index);
  assign free_in_range = (32'(in_slot_index) < 32'(NUM_SLOTS));
  assign wr_en         = cmd.accept && (in_req_type == REQ_FREE) && free_in_range;
  assign rd_en         = cmd.accept && (in_req_type == REQ_ALLOC) && (list_head != NULL_PTR);

  // link store: next pointer of each free slot, no reset
  always_ff @(posedge clk) begin
    if (wr_en) link_mem[slot_ext[AW-1:0]] <= list_head;
    if (rd_en) rd_data <= link_mem[list_head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head   <= NULL_PTR;
      fresh_count <= '0;
      pop         <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pop <= 1'b0;
        if (in_req_type == REQ_FREE) begin
          if (free_in_range) list_head <= slot_ext[PTR_W-1:0];
        end else if (list_head != NULL_PTR) begin
          pop <= 1'b1;
        end else if (fresh_count != NULL_PTR) begin
          fresh_count <= fresh_count + 1'b1;
        end
      end
      if (cmd.link && pop) list_head <= rd_data;
    end
  end

  // chosen slot; zero on failure so the outputs come out zero
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_req_type == REQ_FREE) begin
        ok_r <= free_in_range;
        got  <= free_in_range ? slot_ext[PTR_W-1:0] : '0;
      end else if (list_head != NULL_PTR) begin
        ok_r <= 1'b1;
        got  <= list_head;
      end else if (fresh_count != NULL_PTR) begin
        ok_r <= 1'b1;
        got  <= fresh_count;
      end else begin
        ok_r <= 1'b0;
        got  <= '0;
      end
    end
  end

  // slot size = max(object, pointer) rounded up to the alignment
  always_comb begin
    base_size  = (object_bytes < OBJ_W'(POINTER_BYTES)) ? SIZE_W'(POINTER_BYTES)
                                                        : SIZE_W'(object_bytes);
    align_mask = ~({SIZE_W{1'b1}} << align_log2);
    slot_size  = (base_size + align_mask) & ~align_mask;
  end

  assign prod = MUL_W'(got) * MUL_W'(slot_size);

  always_ff @(posedge clk) begin
    if (cmd.mul) offset_r <= prod[OFF_W-1:0];
  end

  assign got_ext = EXT_W'(got);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ok          <= ok_r;
      out_slot_index  <= got_ext[SLOT_W-1:0];
      out_byte_offset <= offset_r;
    end
  end

  assign status.out_stall = out_valid && !out_ready;

endmodule

FILE: rtl/fixed_slot_free_list_allocator.sv
`timescale 1ns / 1ps

// channel  dir  handshake    payload
// req      in   valid/ready  req_type, slot_index
// rsp      out  valid/ready  ok, slot_index_out, byte_offset
// cfg      in   valid/ready  index, data (ready always high)
//
// One item at a time: accept, link read, offset multiply, output load.
// The result passes the link read, the multiplier register and the output load in turn;
// the next item is taken only after the output load, which a stalled result holds off.
// A result waiting in the output register does not block the next accept.
// Reset (rst, synchronous) empties the free list and zeroes the fresh counter at once.
// A stalled result holds the controller in its load step until rsp.ready.

module fixed_slot_free_list_allocator import fsla_pkg::*; #(
  parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
  parameter int POINTER_BYTES = POINTER_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fsla_req_if.sink  req,
  fsla_rsp_if.source rsp,
  fsla_cfg_if.sink  cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  fsla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fsla_datapath #(
    .NUM_SLOTS     (NUM_SLOTS),
    .POINTER_BYTES (POINTER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_req_type     (req.req_type),
    .in_slot_index   (req.slot_index),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .out_ok          (rsp.ok),
    .out_slot_index  (rsp.slot_index_out),
    .out_byte_offset (rsp.byte_offset)
  );

endmodule

FILE: rtl/fsla_checker.sv
`timescale 1ns / 1ps

module fsla_checker import fsla_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_ok,
  input logic [SLOT_W-1:0] rsp_slot_index_out,
  input logic [OFF_W-1:0]  rsp_byte_offset
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
      && $stable(rsp_slot_index_out) && $stable(rsp_byte_offset))
    else $error("stalled result changed");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // failure results carry zero slot and offset
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_slot_index_out == '0 && rsp_byte_offset == '0)
    else $error("failed result with nonzero payload");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind fixed_slot_free_list_allocator fsla_checker u_fsla_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_ok             (rsp.ok),
  .rsp_slot_index_out (rsp.slot_index_out),
  .rsp_byte_offset    (rsp.byte_offset)
);
